// File: hw/rtl/pmx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmx_pkg
// Shared constants and types of the partially mapped crossover core.
// ----------------------------------------------------------------------------
package pmx_pkg;

    localparam int GENE_W        = 6;
    localparam int CFG_W         = 7;
    localparam int STORE_DEPTH   = 64;
    localparam int MAX_GENES_DEF = 64;
    localparam int MIN_GENES     = 2;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CFG_W-1:0] GENES_RESET = 7'd50;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_CROSS = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t               op;
        logic [GENE_W-1:0] pos;
        logic [GENE_W-1:0] gene_a;
        logic [GENE_W-1:0] gene_b;
        logic [GENE_W-1:0] lo;
        logic [GENE_W-1:0] hi;
        logic [CFG_W-1:0]  count;
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SEG,
        ST_SEG_LAST,
        ST_READ,
        ST_PICK,
        ST_RESOLVE,
        ST_MAP,
        ST_EMIT
    } back_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/pmx_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmx_ram
// Generic memory, one write port and one read port with registered read.
// ----------------------------------------------------------------------------
module pmx_ram
#(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: hw/rtl/pmx_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmx_front
// Holds the gene count register, takes input transfers and turns them into
// commands: cut points ordered and clamped, out-of-range loads dropped.
// ----------------------------------------------------------------------------
module pmx_front
    import pmx_pkg::*;
#(
    parameter int MAX_GENES = MAX_GENES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  genes_in_use,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic [GENE_W-1:0] position,
    input  logic [GENE_W-1:0] gene_first,
    input  logic [GENE_W-1:0] gene_second,
    input  logic [GENE_W-1:0] cut_low,
    input  logic [GENE_W-1:0] cut_high,
    input  logic              queue_full,
    output logic              push,
    output cmd_t              push_cmd
);

    logic [CFG_W-1:0]  genes_reg;
    logic [CFG_W-1:0]  count;
    logic [CFG_W-1:0]  last_idx;
    logic [GENE_W-1:0] lo_ord;
    logic [GENE_W-1:0] hi_ord;
    logic [GENE_W-1:0] lo_clamp;
    logic [GENE_W-1:0] hi_clamp;
    logic              pos_ok;
    op_t               op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            genes_reg <= GENES_RESET;
        end
        else if (cfg_valid)
        begin
            genes_reg <= genes_in_use;
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (genes_reg < CFG_W'(MIN_GENES))
        begin
            count = CFG_W'(MIN_GENES);
        end
        else if (genes_reg > CFG_W'(MAX_GENES))
        begin
            count = CFG_W'(MAX_GENES);
        end
        else
        begin
            count = genes_reg;
        end
    end

    assign last_idx = count - CFG_W'(1);
    assign lo_ord   = (cut_low > cut_high) ? cut_high : cut_low;
    assign hi_ord   = (cut_low > cut_high) ? cut_low : cut_high;
    assign lo_clamp = ({1'b0, lo_ord} > last_idx) ? last_idx[GENE_W-1:0] : lo_ord;
    assign hi_clamp = ({1'b0, hi_ord} > last_idx) ? last_idx[GENE_W-1:0] : hi_ord;
    assign pos_ok   = ({1'b0, position} < CFG_W'(MAX_GENES));
    assign op       = op_t'(operation);

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full && ((op == OP_CROSS) || pos_ok);

    always_comb
    begin
        push_cmd.op     = op;
        push_cmd.pos    = position;
        push_cmd.gene_a = gene_first;
        push_cmd.gene_b = gene_second;
        push_cmd.lo     = lo_clamp;
        push_cmd.hi     = hi_clamp;
        push_cmd.count  = count;
    end

endmodule
`default_nettype wire

// File: hw/rtl/pmx_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmx_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module pmx_queue
    import pmx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entries_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_next;

    assign wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
    assign rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

endmodule
`default_nettype wire

// File: hw/rtl/pmx_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmx_back
// Carries out queued commands: parent loads, segment mapping, duplicate
// resolution by walking the mapping, and gene-by-gene output of both children.
// ----------------------------------------------------------------------------
module pmx_back
    import pmx_pkg::*;
#(
    parameter int MAX_GENES = MAX_GENES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  cmd_t              head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [GENE_W-1:0] out_position,
    output logic [GENE_W-1:0] child_first,
    output logic [GENE_W-1:0] child_second,
    output logic              last
);

    localparam int AW = $clog2(MAX_GENES);
    localparam int MW = $clog2(STORE_DEPTH);

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [GENE_W-1:0] k_reg;
    logic [GENE_W-1:0] v1_reg;
    logic [GENE_W-1:0] v2_reg;
    logic [CFG_W-1:0]  steps1_reg;
    logic [CFG_W-1:0]  steps2_reg;
    logic              need1_reg;
    logic              need2_reg;
    logic              seg_pend_reg;
    logic [STORE_DEPTH-1:0] seg1_reg;
    logic [STORE_DEPTH-1:0] seg2_reg;
    logic              out_valid_reg;
    logic [GENE_W-1:0] out_position_reg;
    logic [GENE_W-1:0] child_first_reg;
    logic [GENE_W-1:0] child_second_reg;
    logic              last_reg;

    logic              par_we;
    logic [AW-1:0]     par_waddr;
    logic [AW-1:0]     par_raddr;
    logic [GENE_W-1:0] par1_rdata;
    logic [GENE_W-1:0] par2_rdata;
    logic [GENE_W-1:0] map1_rdata;
    logic [GENE_W-1:0] map2_rdata;

    logic              need1;
    logic              need2;
    logic              emit;
    logic              last_gene;
    logic              in_seg;
    logic [CFG_W-1:0]  seg_len;

    assign need1     = (steps1_reg != '0) && seg1_reg[v1_reg];
    assign need2     = (steps2_reg != '0) && seg2_reg[v2_reg];
    assign last_gene = ({1'b0, k_reg} == (head.count - CFG_W'(1)));
    assign in_seg    = (k_reg >= head.lo) && (k_reg <= head.hi);
    assign seg_len   = CFG_W'(head.hi) - CFG_W'(head.lo) + CFG_W'(1);

    // parent and mapping stores
    pmx_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_par1 (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (head.gene_a),
        .raddr (par_raddr),
        .rdata (par1_rdata)
    );

    pmx_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_par2 (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (head.gene_b),
        .raddr (par_raddr),
        .rdata (par2_rdata)
    );

    pmx_ram #(.WIDTH(GENE_W), .DEPTH(STORE_DEPTH)) u_map12 (
        .clk   (clk),
        .we    (seg_pend_reg),
        .waddr (par1_rdata[MW-1:0]),
        .wdata (par2_rdata),
        .raddr (v1_reg[MW-1:0]),
        .rdata (map1_rdata)
    );

    pmx_ram #(.WIDTH(GENE_W), .DEPTH(STORE_DEPTH)) u_map21 (
        .clk   (clk),
        .we    (seg_pend_reg),
        .waddr (par2_rdata[MW-1:0]),
        .wdata (par1_rdata),
        .raddr (v2_reg[MW-1:0]),
        .rdata (map2_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && (head.op == OP_CROSS))
                begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG:
            begin
                if (k_reg == head.hi)
                begin
                    state_next = ST_SEG_LAST;
                end
            end
            ST_SEG_LAST:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                state_next = (need1 || need2) ? ST_MAP : ST_EMIT;
            end
            ST_MAP:
            begin
                state_next = ST_RESOLVE;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = last_gene ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        par_we    = 1'b0;
        par_waddr = head.pos[AW-1:0];
        par_raddr = k_reg[AW-1:0];
        pop       = 1'b0;
        emit      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && (head.op == OP_LOAD))
                begin
                    par_we = 1'b1;
                    pop    = 1'b1;
                end
            end
            ST_EMIT:
            begin
                emit = !out_valid_reg || !out_stall;
                pop  = emit && last_gene;
            end
            default:
            begin
                par_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seg_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            seg_pend_reg <= (state_reg == ST_SEG);
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_pend_reg)
        begin
            seg1_reg[par1_rdata[MW-1:0]] <= 1'b1;
            seg2_reg[par2_rdata[MW-1:0]] <= 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                k_reg    <= head.lo;
                seg1_reg <= '0;
                seg2_reg <= '0;
            end
            ST_SEG:
            begin
                k_reg <= k_reg + GENE_W'(1);
            end
            ST_SEG_LAST:
            begin
                k_reg <= '0;
            end
            ST_PICK:
            begin
                v1_reg     <= in_seg ? par1_rdata : par2_rdata;
                v2_reg     <= in_seg ? par2_rdata : par1_rdata;
                steps1_reg <= in_seg ? '0 : seg_len;
                steps2_reg <= in_seg ? '0 : seg_len;
            end
            ST_RESOLVE:
            begin
                need1_reg <= need1;
                need2_reg <= need2;
            end
            ST_MAP:
            begin
                if (need1_reg)
                begin
                    v1_reg     <= map1_rdata;
                    steps1_reg <= steps1_reg - CFG_W'(1);
                end
                if (need2_reg)
                begin
                    v2_reg     <= map2_rdata;
                    steps2_reg <= steps2_reg - CFG_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    k_reg            <= k_reg + GENE_W'(1);
                    out_position_reg <= k_reg;
                    child_first_reg  <= v1_reg;
                    child_second_reg <= v2_reg;
                    last_reg         <= last_gene;
                end
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign out_position = out_position_reg;
    assign child_first  = child_first_reg;
    assign child_second = child_second_reg;
    assign last         = last_reg;

endmodule
`default_nettype wire

// File: hw/rtl/pmx_permutation_crossover_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Load transfer: loads may follow one another every cycle while in_stall is low.
// Cross transfer: ST_SEG and ST_SEG_LAST build the segment mapping, then each gene passes ST_READ,
// ST_PICK, ST_RESOLVE, one ST_MAP and ST_RESOLVE pair per step of the longer duplicate walk, and ST_EMIT.
// Every step of the walk is one registered read of the mapping store.
// Reset: gene count 50, command queue and output empty; stores keep content.
// ----------------------------------------------------------------------------
// pmx_permutation_crossover_core
// Partially mapped crossover of two permutation chromosomes.
// ----------------------------------------------------------------------------
module pmx_permutation_crossover_core
    import pmx_pkg::*;
#(
    parameter int MAX_GENES = MAX_GENES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  genes_in_use,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic [GENE_W-1:0] position,
    input  logic [GENE_W-1:0] gene_first,
    input  logic [GENE_W-1:0] gene_second,
    input  logic [GENE_W-1:0] cut_low,
    input  logic [GENE_W-1:0] cut_high,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [GENE_W-1:0] out_position,
    output logic [GENE_W-1:0] child_first,
    output logic [GENE_W-1:0] child_second,
    output logic              last
);

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic pop;
    logic head_valid;
    cmd_t head;

    pmx_front #(.MAX_GENES(MAX_GENES)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .genes_in_use (genes_in_use),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .position     (position),
        .gene_first   (gene_first),
        .gene_second  (gene_second),
        .cut_low      (cut_low),
        .cut_high     (cut_high),
        .queue_full   (queue_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    pmx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    pmx_back #(.MAX_GENES(MAX_GENES)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_position (out_position),
        .child_first  (child_first),
        .child_second (child_second),
        .last         (last)
    );

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmx crossover core testbench
// Loads parent chromosomes, runs crossovers at a range of gene counts and cut
// points, and checks every emitted child gene against an in-bench predictor.
// Both handshakes are idled at random, and a watchdog bounds the run.
// ----------------------------------------------------------------------------
module testbench;

    import pmx_pkg::*;

    localparam int SETTLE_CYCLES = 32;
    localparam int STALL_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 260;

    typedef struct packed
    {
        logic [GENE_W-1:0] pos;
        logic [GENE_W-1:0] kid_a;
        logic [GENE_W-1:0] kid_b;
        logic              tail;
    } child_gene_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  genes_in_use;
    logic              in_valid;
    logic              in_stall;
    logic              operation;
    logic [GENE_W-1:0] position;
    logic [GENE_W-1:0] gene_first;
    logic [GENE_W-1:0] gene_second;
    logic [GENE_W-1:0] cut_low;
    logic [GENE_W-1:0] cut_high;
    logic              out_valid;
    logic              out_stall;
    logic [GENE_W-1:0] out_position;
    logic [GENE_W-1:0] child_first;
    logic [GENE_W-1:0] child_second;
    logic              last;

    logic [GENE_W-1:0] par_a [STORE_DEPTH];
    logic [GENE_W-1:0] par_b [STORE_DEPTH];
    logic [GENE_W-1:0] map_ab [STORE_DEPTH];
    logic [GENE_W-1:0] map_ba [STORE_DEPTH];
    logic [CFG_W-1:0]  gene_count;
    child_gene_t       child_q [$];
    child_gene_t       want;
    int                mismatches = 0;
    int                items_sent = 0;
    int                quiet_cycles = 0;
    bit                steady = 1'b0;

    pmx_permutation_crossover_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .genes_in_use (genes_in_use),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .position     (position),
        .gene_first   (gene_first),
        .gene_second  (gene_second),
        .cut_low      (cut_low),
        .cut_high     (cut_high),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_position (out_position),
        .child_first  (child_first),
        .child_second (child_second),
        .last         (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int genes_effective(input logic [CFG_W-1:0] raw);
        if (raw < MIN_GENES)
            return MIN_GENES;
        if (raw > MAX_GENES_DEF)
            return MAX_GENES_DEF;
        return int'(raw);
    endfunction

    // follow the segment mapping until the gene is not in the other parent's segment, at most hi - lo + 1 steps
    function automatic logic [GENE_W-1:0] settle_gene(input bit from_a, input int lo,
                                                      input int hi,
                                                      input logic [GENE_W-1:0] v);
        int steps;
        int j;
        bit hit;
        steps = hi - lo + 1;
        while (steps > 0)
        begin
            hit = 1'b0;
            for (j = lo; j <= hi; j++)
                if ((from_a ? par_a[j] : par_b[j]) == v)
                    hit = 1'b1;
            if (!hit)
                break;
            v = from_a ? map_ab[v] : map_ba[v];
            steps--;
        end
        return v;
    endfunction

    function automatic void predict_children(input logic [GENE_W-1:0] cl,
                                             input logic [GENE_W-1:0] ch);
        int n;
        int lo;
        int hi;
        int t;
        int k;
        child_gene_t g;
        n = genes_effective(gene_count);
        lo = int'(cl);
        hi = int'(ch);
        if (lo > hi)
        begin
            t = lo;
            lo = hi;
            hi = t;
        end
        if (lo > n - 1)
            lo = n - 1;
        if (hi > n - 1)
            hi = n - 1;
        for (k = lo; k <= hi; k++)
        begin
            map_ab[par_a[k]] = par_b[k];
            map_ba[par_b[k]] = par_a[k];
        end
        for (k = 0; k < n; k++)
        begin
            g.pos = GENE_W'(k);
            if (k >= lo && k <= hi)
            begin
                g.kid_a = par_a[k];
                g.kid_b = par_b[k];
            end
            else
            begin
                g.kid_a = settle_gene(1'b1, lo, hi, par_b[k]);
                g.kid_b = settle_gene(1'b0, lo, hi, par_a[k]);
            end
            g.tail = (k == n - 1);
            child_q.push_back(g);
        end
    endfunction

    task automatic send_item(input op_t op, input logic [GENE_W-1:0] pos,
                             input logic [GENE_W-1:0] ga, input logic [GENE_W-1:0] gb,
                             input logic [GENE_W-1:0] cl, input logic [GENE_W-1:0] ch);
        @(negedge clk);
        if (!steady && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < 30)
                @(negedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        position    <= pos;
        gene_first  <= ga;
        gene_second <= gb;
        cut_low     <= cl;
        cut_high    <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (op == OP_LOAD)
        begin
            par_a[pos] = ga;
            par_b[pos] = gb;
        end
        else
            predict_children(cl, ch);
    endtask

    task automatic send_load(input int pos, input logic [GENE_W-1:0] ga,
                             input logic [GENE_W-1:0] gb);
        send_item(OP_LOAD, GENE_W'(pos), ga, gb, GENE_W'($urandom_range(0, 63)),
                  GENE_W'($urandom_range(0, 63)));
    endtask

    task automatic send_cross(input int cl, input int ch);
        send_item(OP_CROSS, GENE_W'($urandom_range(0, 63)), GENE_W'($urandom_range(0, 63)),
                  GENE_W'($urandom_range(0, 63)), GENE_W'(cl), GENE_W'(ch));
    endtask

    task automatic wait_until_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (child_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_gene_count(input logic [CFG_W-1:0] value);
        wait_until_idle();
        cfg_valid    <= 1'b1;
        genes_in_use <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        gene_count = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // two parents over the same random gene set, or random genes when broken
    task automatic load_parents(input int n, input bit permutation);
        logic [GENE_W-1:0] pool [STORE_DEPTH];
        logic [GENE_W-1:0] other [STORE_DEPTH];
        logic [GENE_W-1:0] t;
        int k;
        int j;
        for (k = 0; k < STORE_DEPTH; k++)
            pool[k] = GENE_W'(k);
        for (k = STORE_DEPTH - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = pool[k];
            pool[k] = pool[j];
            pool[j] = t;
        end
        for (k = 0; k < n; k++)
            other[k] = pool[k];
        for (k = n - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = other[k];
            other[k] = other[j];
            other[j] = t;
        end
        for (k = 0; k < n; k++)
            if (permutation)
                send_load(k, pool[k], other[k]);
            else
                send_load(k, GENE_W'($urandom_range(0, 63)), GENE_W'($urandom_range(0, 63)));
    endtask

    task automatic test_default_gene_count();
        int k;
        for (k = 0; k < STORE_DEPTH; k++)
            send_load(k, GENE_W'(k), GENE_W'(STORE_DEPTH - 1 - k));
        send_cross(10, 40);
    endtask

    task automatic test_cut_points();
        write_gene_count(7'd8);
        load_parents(8, 1'b1);
        send_cross(0, 0);
        send_cross(63, 0);
        send_cross(63, 63);
        send_cross(5, 2);
        send_cross(5, 2);
    endtask

    task automatic test_non_permutation();
        int k;
        for (k = 0; k < 8; k++)
            send_load(k, 6'd63, GENE_W'(k % 2));
        send_cross(2, 5);
    endtask

    task automatic test_gene_count_extremes();
        write_gene_count(7'd0);
        send_cross($urandom_range(0, 63), $urandom_range(0, 63));
        write_gene_count(7'd1);
        send_cross(0, 1);
        write_gene_count(7'd2);
        send_cross(1, 1);
        write_gene_count(7'd64);
        send_cross(20, 45);
        write_gene_count(7'd65);
        send_cross(0, 63);
        write_gene_count(7'd127);
        send_cross($urandom_range(0, 63), $urandom_range(0, 63));
    endtask

    task automatic test_random_crossover();
        int start;
        int phase;
        int n;
        logic [CFG_W-1:0] raw;
        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            steady = (phase == 3 || phase == 4);
            case ($urandom_range(0, 15))
                0: raw = CFG_W'($urandom_range(0, 127));
                1: raw = 7'd64;
                default: raw = CFG_W'($urandom_range(2, 12));
            endcase
            write_gene_count(raw);
            n = genes_effective(raw);
            repeat (n > 16 ? 1 : $urandom_range(1, 3))
            begin
                load_parents(n, $urandom_range(0, 9) != 0);
                repeat ($urandom_range(1, 3))
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_load($urandom_range(0, 63), GENE_W'($urandom_range(0, 63)),
                                  GENE_W'($urandom_range(0, 63)));
                    if ($urandom_range(0, 4) == 0)
                        send_cross($urandom_range(0, 63), $urandom_range(0, 63));
                    else
                        send_cross($urandom_range(0, n - 1), $urandom_range(0, n - 1));
                end
            end
            phase++;
        end
        steady = 1'b0;
    endtask

    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < 16);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (child_q.size() == 0)
            begin
                $error("child gene transfer with no crossover pending, position %0d",
                       out_position);
                mismatches++;
            end
            else
            begin
                want = child_q.pop_front();
                if (out_position !== want.pos)
                begin
                    $error("out_position expected %0d got %0d", want.pos, out_position);
                    mismatches++;
                end
                if (child_first !== want.kid_a)
                begin
                    $error("child_first expected %0d got %0d", want.kid_a, child_first);
                    mismatches++;
                end
                if (child_second !== want.kid_b)
                begin
                    $error("child_second expected %0d got %0d", want.kid_b, child_second);
                    mismatches++;
                end
                if (last !== want.tail)
                begin
                    $error("last expected %0d got %0d", want.tail, last);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        genes_in_use = GENES_RESET;
        in_valid     = 1'b0;
        operation    = OP_LOAD;
        position     = '0;
        gene_first   = '0;
        gene_second  = '0;
        cut_low      = '0;
        cut_high     = '0;
        out_stall    = 1'b0;
        gene_count   = GENES_RESET;
        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            par_a[k]  = '0;
            par_b[k]  = '0;
            map_ab[k] = '0;
            map_ba[k] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_gene_count();
        test_cut_points();
        test_non_permutation();
        test_gene_count_extremes();
        test_random_crossover();

        wait_until_idle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
